### hw/rtl/box_filter_3x3_rgb_unit_assert.svh
// Assertion macros for the 3x3 box filter.
// BF3_ASSERT checks a property with reset as a disable condition.
// BF3_ASSERT_IN_RESET checks a property at every edge, reset included.
`ifndef BOX_FILTER_3X3_RGB_UNIT_ASSERT_SVH
`define BOX_FILTER_3X3_RGB_UNIT_ASSERT_SVH
`ifndef SYNTH
`define BF3_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BF3_ASSERT_IN_RESET(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BF3_ASSERT(lbl, clk, rstn, prop, msg)
`define BF3_ASSERT_IN_RESET(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/bf3_pkg.sv
`default_nettype none

package bf3_pkg;

    // Pixel layout: red in the low byte, then green, then blue.
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int PIX_W     = CH_W * NUM_CH;
    localparam int COL_SUM_W = 10;
    localparam int WIN_SUM_W = 12;
    localparam int CFG_W     = 9;

    // Reset value of both size registers.
    localparam logic [CFG_W-1:0] CFG_RESET = 9'd220;

    // Register indexes of the configuration channel.
    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Item kinds on the input channel.
    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } item_kind_t;

    // Division by nine as a multiply by ceil(2^15 / 9) and a shift.
    // Exact for every dividend below 2^15.
    localparam logic [11:0] DIV9_RECIP = 12'd3641;
    localparam int          DIV9_SHIFT = 15;
    localparam logic [12:0] ROUND_BIAS = 13'd4;
    localparam logic [9:0]  CH_MAX     = 10'd255;

    typedef logic [PIX_W-1:0]     pixel_t;
    typedef logic [WIN_SUM_W-1:0] win_sum_t;
    typedef win_sum_t [NUM_CH-1:0] win_sums_t;

    // Control that travels with an item from the input stage to the window.
    typedef struct packed {
        logic col_zero;
        logic top_ok;
        logic mid_ok;
        logic have;
        logic last;
    } s1_ctrl_t;

    // Rounded mean of nine 8-bit values, clamped to the channel range.
    function automatic logic [CH_W-1:0] mean9(input win_sum_t sum);
        logic [12:0] biased;
        logic [24:0] prod;
        logic [9:0]  quot;
        biased = 13'(sum) + ROUND_BIAS;
        prod   = 25'(biased) * 25'(DIV9_RECIP);
        quot   = prod[DIV9_SHIFT +: 10];
        if (quot > CH_MAX) begin
            return CH_MAX[CH_W-1:0];
        end
        return quot[CH_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/bf3_row_mem.sv
`default_nettype none

// Line buffer: each entry holds the two rows above one column.
// One read port with registered data and one write port.
module bf3_row_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 48
) (
    input  wire logic          aclk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/bf3_window.sv
`default_nettype none

// Sliding 3x3 window kept as per-channel column sums of the two
// older columns. The newest column is summed on the fly.
module bf3_window (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              shift_en,
    input  wire logic              col_zero,
    input  wire bf3_pkg::pixel_t   top_pix,
    input  wire bf3_pkg::pixel_t   mid_pix,
    input  wire bf3_pkg::pixel_t   new_pix,
    output bf3_pkg::win_sums_t     win_sums
);

    localparam int CW = bf3_pkg::CH_W;
    localparam int SW = bf3_pkg::COL_SUM_W;

    logic [SW-1:0] col_a_reg  [bf3_pkg::NUM_CH];
    logic [SW-1:0] col_b_reg  [bf3_pkg::NUM_CH];
    logic [SW-1:0] col_a_next [bf3_pkg::NUM_CH];
    logic [SW-1:0] col_b_next [bf3_pkg::NUM_CH];
    logic [SW-1:0] col_new    [bf3_pkg::NUM_CH];

    // Column sum of the incoming column and the window total. At the first
    // column of a row the window holds the right edge of the row above, so
    // the incoming column is padding for that result.
    always_comb begin
        for (int ch = 0; ch < bf3_pkg::NUM_CH; ch++) begin
            col_new[ch] = SW'(top_pix[ch*CW +: CW]) + SW'(mid_pix[ch*CW +: CW])
                        + SW'(new_pix[ch*CW +: CW]);
            win_sums[ch] = bf3_pkg::WIN_SUM_W'(col_a_reg[ch])
                         + bf3_pkg::WIN_SUM_W'(col_b_reg[ch])
                         + (col_zero ? '0 : bf3_pkg::WIN_SUM_W'(col_new[ch]));
            if (col_zero) begin
                col_a_next[ch] = '0;
            end else begin
                col_a_next[ch] = col_b_reg[ch];
            end
            col_b_next[ch] = col_new[ch];
        end
    end

    // Shift the window by one column per item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int ch = 0; ch < bf3_pkg::NUM_CH; ch++) begin
                col_a_reg[ch] <= '0;
                col_b_reg[ch] <= '0;
            end
        end else if (shift_en) begin
            for (int ch = 0; ch < bf3_pkg::NUM_CH; ch++) begin
                col_a_reg[ch] <= col_a_next[ch];
                col_b_reg[ch] <= col_b_next[ch];
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/box_filter_3x3_rgb_unit.sv
// Channel   Direction  Handshake            Contents
// s_        in         s_tvalid/s_tready    one pixel or flush item
// m_        out        m_tvalid/m_tready    one filtered pixel, tlast on frame end
// cfg_      in         cfg_valid/cfg_ready  image_width (0), image_height (1)
//
// One item per clock unless the output stalls. Stages: line buffer read with window
// sums, the sum register, then divide by nine into the output register.
// A pixel's result comes one row plus one pixel later; width + 1 flush items end a frame.
// Reset clears the pipeline, counters and window and sets both sizes to 220.
// The line buffer is not cleared; rows outside the image are masked to zero.
// With m_tready low the output holds, the inner stages fill and s_tready falls.
`default_nettype none

module box_filter_3x3_rgb_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Input items
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [23:0]               s_tdata,  // red_in, green_in, blue_in
    input  wire logic                      s_tuser,  // kind
    // Result items
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [23:0]                    m_tdata,  // red_out, green_out, blue_out
    output logic                           m_tlast,  // frame_end
    // Configuration writes
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [0:0]                cfg_index,
    input  wire logic [bf3_pkg::CFG_W-1:0] cfg_data
);

`include "box_filter_3x3_rgb_unit_assert.svh"

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int RW   = $clog2(MAX_HEIGHT + 3);
    localparam int WCMP = (WW > bf3_pkg::CFG_W) ? WW : bf3_pkg::CFG_W;
    localparam int HCMP = (HW > bf3_pkg::CFG_W) ? HW : bf3_pkg::CFG_W;
    localparam int PW   = bf3_pkg::PIX_W;
    localparam int CHW  = bf3_pkg::CH_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [bf3_pkg::CFG_W-1:0] cfg_width_reg;
    logic [bf3_pkg::CFG_W-1:0] cfg_height_reg;
    logic                      cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= bf3_pkg::CFG_RESET;
            cfg_height_reg <= bf3_pkg::CFG_RESET;
        end else if (cfg_write) begin
            if (cfg_index == bf3_pkg::CFG_IMAGE_WIDTH) begin
                cfg_width_reg <= cfg_data;
            end else begin
                cfg_height_reg <= cfg_data;
            end
        end
    end

    // Sizes in use, clamped to 1..MAX.
    logic [WW-1:0] width_use;
    logic [HW-1:0] height_use;

    always_comb begin
        if (cfg_width_reg == '0) begin
            width_use = WW'(1);
        end else if (WCMP'(cfg_width_reg) > WCMP'(MAX_WIDTH)) begin
            width_use = WW'(MAX_WIDTH);
        end else begin
            width_use = WW'(cfg_width_reg);
        end
        if (cfg_height_reg == '0) begin
            height_use = HW'(1);
        end else if (HCMP'(cfg_height_reg) > HCMP'(MAX_HEIGHT)) begin
            height_use = HW'(MAX_HEIGHT);
        end else begin
            height_use = HW'(cfg_height_reg);
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic s2_have_reg;
    logic s2_last_reg;
    logic s_accept;
    logic s1_move;
    logic s2_move;
    logic out_load;

    assign s2_move  = s2_valid_reg && (!s2_have_reg || !m_tvalid_reg || m_tready);
    assign out_load = s2_move && s2_have_reg;
    assign s1_move  = s1_valid_reg && (!s2_valid_reg || s2_move);
    assign s_tready = !s1_valid_reg || s1_move;
    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Input stage: position tracking and masks
    // ------------------------------------------------------------------
    logic [CW-1:0]     in_col_reg, in_col_next;
    logic [RW-1:0]     in_row_reg, in_row_next;
    logic [CW-1:0]     s0_col;
    logic [RW-1:0]     s0_row;
    logic [RW-1:0]     h_rw;
    logic [WW-1:0]     col_inc;
    logic [CW-1:0]     col_step;
    logic [RW-1:0]     row_step;
    logic              s0_restart;
    logic              s0_pix_ok;
    bf3_pkg::s1_ctrl_t s0_ctrl;

    assign h_rw = RW'(height_use);

    always_comb begin
        // A position outside the frame and its flush span restarts the frame.
        s0_restart = (WW'(in_col_reg) >= width_use) || (in_row_reg > h_rw + RW'(1));
        s0_col     = s0_restart ? '0 : in_col_reg;
        s0_row     = s0_restart ? '0 : in_row_reg;

        s0_ctrl.col_zero = (s0_col == '0);
        s0_ctrl.top_ok   = (s0_row >= RW'(2)) && (s0_row <= h_rw + RW'(1));
        s0_ctrl.mid_ok   = (s0_row >= RW'(1)) && (s0_row <= h_rw);
        s0_ctrl.have     = s0_ctrl.col_zero ? s0_ctrl.top_ok : s0_ctrl.mid_ok;
        s0_ctrl.last     = s0_ctrl.col_zero && (s0_row == h_rw + RW'(1));
        s0_pix_ok        = (s_tuser == bf3_pkg::KIND_PIXEL) && (s0_row < h_rw);

        // Advance to the next position.
        col_inc = WW'(s0_col) + WW'(1);
        if (col_inc >= width_use) begin
            col_step = '0;
            row_step = s0_row + RW'(1);
        end else begin
            col_step = CW'(col_inc);
            row_step = s0_row;
        end
        if (s0_ctrl.last || (row_step > h_rw + RW'(1))) begin
            col_step = '0;
            row_step = '0;
        end

        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        if (s_accept) begin
            in_col_next = col_step;
            in_row_next = row_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg <= '0;
            in_row_reg <= '0;
        end else begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line buffer and window stage
    // ------------------------------------------------------------------
    bf3_pkg::pixel_t   s1_pix_reg;
    logic [CW-1:0]     s1_addr_reg;
    bf3_pkg::s1_ctrl_t s1_ctrl_reg;
    logic              s1_fwd_reg;
    logic [2*PW-1:0]   s1_fwd_data_reg;
    logic [2*PW-1:0]   mem_rd_data;
    logic [2*PW-1:0]   s1_rows;
    logic [2*PW-1:0]   s1_wr_data;
    bf3_pkg::pixel_t   top_raw;
    bf3_pkg::pixel_t   mid_raw;
    bf3_pkg::pixel_t   top_pix;
    bf3_pkg::pixel_t   mid_pix;
    bf3_pkg::win_sums_t win_sums;
    logic              fwd_hit;

    bf3_row_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (2 * PW)
    ) u_row_mem (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (s0_col),
        .rd_data (mem_rd_data),
        .wr_en   (s1_move),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_wr_data)
    );

    // Rows above this column; a write to the same column in the cycle of
    // the read is taken from the forwarding register.
    always_comb begin
        s1_rows    = s1_fwd_reg ? s1_fwd_data_reg : mem_rd_data;
        top_raw    = s1_rows[2*PW-1:PW];
        mid_raw    = s1_rows[PW-1:0];
        top_pix    = s1_ctrl_reg.top_ok ? top_raw : '0;
        mid_pix    = s1_ctrl_reg.mid_ok ? mid_raw : '0;
        s1_wr_data = {mid_raw, s1_pix_reg};
        fwd_hit    = s1_move && (s1_addr_reg == s0_col);
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pix_reg      <= s0_pix_ok ? s_tdata : '0;
            s1_addr_reg     <= s0_col;
            s1_ctrl_reg     <= s0_ctrl;
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_data_reg <= s1_wr_data;
        end
    end

    bf3_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (s1_move),
        .col_zero (s1_ctrl_reg.col_zero),
        .top_pix  (top_pix),
        .mid_pix  (mid_pix),
        .new_pix  (s1_pix_reg),
        .win_sums (win_sums)
    );

    // ------------------------------------------------------------------
    // Sum register
    // ------------------------------------------------------------------
    bf3_pkg::win_sums_t s2_sums_reg;

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            s2_sums_reg <= win_sums;
            s2_have_reg <= s1_ctrl_reg.have;
            s2_last_reg <= s1_ctrl_reg.last;
        end
    end

    // ------------------------------------------------------------------
    // Divide by nine into the output register
    // ------------------------------------------------------------------
    logic [PW-1:0] m_tdata_reg;
    logic          m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            for (int ch = 0; ch < bf3_pkg::NUM_CH; ch++) begin
                m_tdata_reg[ch*CHW +: CHW] <= bf3_pkg::mean9(s2_sums_reg[ch]);
            end
            m_tlast_reg <= s2_last_reg;
        end
    end

    // Valid bits of the three stages.
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
        s2_valid_next = s2_valid_reg;
        if (s1_move) begin
            s2_valid_next = 1'b1;
        end else if (s2_move) begin
            s2_valid_next = 1'b0;
        end
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic pipe_empty;
    logic frame_done;
    logic at_origin;

    assign pipe_empty = !m_tvalid_reg && !s1_valid_reg && !s2_valid_reg;
    assign frame_done = s_accept && s0_ctrl.last;
    assign at_origin  = (in_col_reg == '0) && (in_row_reg == '0);

    `BF3_ASSERT_IN_RESET(a_reset_empties, aclk, !aresetn |=> pipe_empty, "reset left an item")
    `BF3_ASSERT(a_accept_fills_s1, aclk, aresetn, s_accept |=> s1_valid_reg, "item lost at input")
    `BF3_ASSERT(a_frame_end_restarts, aclk, aresetn, frame_done |=> at_origin, "no frame restart")
    `BF3_ASSERT(a_out_load_shows, aclk, aresetn, out_load |=> m_tvalid, "result not shown")
    `BF3_ASSERT(a_out_last, aclk, aresetn, out_load |=> m_tlast == $past(s2_last_reg), "bad tlast")

endmodule

`default_nettype wire

### verif/bf3_mean_checker.sv
`timescale 1ns / 1ps

// Watches the input, result and configuration channels of the 3x3 box filter.
// Every accepted input item is run through a local model of the filter, and
// every accepted result is compared with the oldest predicted mean.
module bf3_mean_checker #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    input  wire logic                      s_tready,
    input  wire logic [23:0]               s_tdata,   // red_in, green_in, blue_in
    input  wire logic                      s_tuser,   // kind
    input  wire logic                      m_tvalid,
    input  wire logic                      m_tready,
    input  wire logic [23:0]               m_tdata,   // red_out, green_out, blue_out
    input  wire logic                      m_tlast,   // frame_end
    input  wire logic                      cfg_valid,
    input  wire logic                      cfg_ready,
    input  wire logic [0:0]                cfg_index,
    input  wire logic [bf3_pkg::CFG_W-1:0] cfg_data,
    output int                             pending_items,
    output int                             fail_count
);

    localparam int TAPS       = 9;
    localparam int ROUND_HALF = 4;
    localparam int CHAN_MAX   = 255;
    localparam int CHW        = bf3_pkg::CH_W;

    typedef struct {
        bf3_pkg::pixel_t pix;
        logic            frame_end;
    } mean_item_t;

    string chan_name [bf3_pkg::NUM_CH] = '{"red", "green", "blue"};

    // Local copy of the size registers and of the filter state.
    logic [bf3_pkg::CFG_W-1:0] width_reg;
    logic [bf3_pkg::CFG_W-1:0] height_reg;
    bf3_pkg::pixel_t           line_buf [2][MAX_WIDTH];
    bf3_pkg::pixel_t           win_taps [TAPS];
    int unsigned               in_col;
    int unsigned               in_row;

    mean_item_t       mean_q [$];
    mean_item_t       want;
    int               mismatches;
    int               results_seen;

    function automatic int unsigned eff_size(input logic [bf3_pkg::CFG_W-1:0] v,
                                             input int unsigned limit);
        if (v == '0) begin
            return 1;
        end
        if (32'(v) > limit) begin
            return limit;
        end
        return 32'(v);
    endfunction

    // Rounded mean of each channel over the nine taps, clamped to the byte range.
    function automatic bf3_pkg::pixel_t box_mean(input bf3_pkg::pixel_t taps [TAPS]);
        bf3_pkg::pixel_t res;
        int unsigned     sum;
        int unsigned     q;
        int              ch;
        int              i;
        res = '0;
        for (ch = 0; ch < bf3_pkg::NUM_CH; ch++) begin
            sum = 0;
            for (i = 0; i < TAPS; i++) begin
                sum += 32'(taps[i][ch*CHW +: CHW]);
            end
            q = (sum + ROUND_HALF) / TAPS;
            if (q > CHAN_MAX) begin
                q = CHAN_MAX;
            end
            res[ch*CHW +: CHW] = q[CHW-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Advances the filter model by one input item and queues the mean it yields.
    task automatic filter_pixel_item(input bf3_pkg::item_kind_t kind,
                                     input bf3_pkg::pixel_t data);
        int unsigned     w;
        int unsigned     h;
        int unsigned     col;
        int unsigned     row;
        int unsigned     out_r;
        int unsigned     out_c;
        bf3_pkg::pixel_t pix;
        bf3_pkg::pixel_t top_px;
        bf3_pkg::pixel_t mid_px;
        bf3_pkg::pixel_t used [TAPS];
        bit              have;
        bit              last;
        int              i;
        mean_item_t      res;
        w = eff_size(width_reg, MAX_WIDTH);
        h = eff_size(height_reg, MAX_HEIGHT);
        col = in_col;
        row = in_row;
        have = 1'b0;
        last = 1'b0;
        out_r = 0;
        out_c = 0;

        // A position outside the frame and its flush span restarts the frame.
        if (col >= w || row > h + 1) begin
            col = 0;
            row = 0;
        end

        // Flush items and anything below the image enter as black pixels.
        pix = '0;
        if (kind == bf3_pkg::KIND_PIXEL && row < h) begin
            pix = data;
        end

        top_px = line_buf[0][col];
        mid_px = line_buf[1][col];
        line_buf[0][col] = mid_px;
        line_buf[1][col] = pix;
        if (!(row >= 2 && row - 2 < h)) begin
            top_px = '0;
        end
        if (!(row >= 1 && row - 1 < h)) begin
            mid_px = '0;
        end

        if (col == 0) begin
            // The window closes the last pixel of a row, padded on its right.
            for (i = 0; i < 3; i++) begin
                used[i]     = win_taps[3 + i];
                used[3 + i] = win_taps[6 + i];
                used[6 + i] = '0;
            end
            if (row >= 2) begin
                out_r = row - 2;
                out_c = w - 1;
                have  = 1'b1;
            end
            for (i = 0; i < 6; i++) begin
                win_taps[i] = '0;
            end
        end else begin
            for (i = 0; i < 6; i++) begin
                win_taps[i] = win_taps[i + 3];
            end
        end
        win_taps[6] = top_px;
        win_taps[7] = mid_px;
        win_taps[8] = pix;
        if (col != 0) begin
            used = win_taps;
            if (row >= 1) begin
                out_r = row - 1;
                out_c = col - 1;
                have  = 1'b1;
            end
        end

        if (have && out_r < h) begin
            last = (out_r == h - 1 && out_c == w - 1);
            res.pix       = box_mean(used);
            res.frame_end = last;
            mean_q.push_back(res);
        end

        col++;
        if (col >= w) begin
            col = 0;
            row++;
        end
        if (last || row > h + 1) begin
            col = 0;
            row = 0;
        end
        in_col = col;
        in_row = row;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = bf3_pkg::CFG_RESET;
            height_reg = bf3_pkg::CFG_RESET;
            for (int b = 0; b < 2; b++) begin
                for (int c = 0; c < MAX_WIDTH; c++) begin
                    line_buf[b][c] = '0;
                end
            end
            for (int t = 0; t < TAPS; t++) begin
                win_taps[t] = '0;
            end
            in_col = 0;
            in_row = 0;
            mean_q.delete();
            mismatches   = 0;
            results_seen = 0;
        end else begin
            // Results are compared before this edge's input item is predicted.
            if (m_tvalid && m_tready) begin
                if (mean_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d unexpected: tdata %h tlast %b",
                                              results_seen, m_tdata, m_tlast));
                end else begin
                    want = mean_q.pop_front();
                    for (int ch = 0; ch < bf3_pkg::NUM_CH; ch++) begin
                        if (m_tdata[ch*CHW +: CHW] !== want.pix[ch*CHW +: CHW]) begin
                            report_mismatch($sformatf("result %0d %s: got %0d want %0d",
                                results_seen, chan_name[ch], m_tdata[ch*CHW +: CHW],
                                want.pix[ch*CHW +: CHW]));
                        end
                    end
                    if (m_tlast !== want.frame_end) begin
                        report_mismatch($sformatf("result %0d frame_end: got %b want %b",
                                                  results_seen, m_tlast, want.frame_end));
                    end
                end
                results_seen++;
            end

            if (cfg_valid && cfg_ready) begin
                case (bf3_pkg::cfg_reg_t'(cfg_index))
                    bf3_pkg::CFG_IMAGE_WIDTH: begin
                        width_reg = cfg_data;
                    end
                    bf3_pkg::CFG_IMAGE_HEIGHT: begin
                        height_reg = cfg_data;
                    end
                    default: begin
                    end
                endcase
            end

            if (s_tvalid && s_tready) begin
                filter_pixel_item(bf3_pkg::item_kind_t'(s_tuser), s_tdata);
            end
        end
        pending_items <= mean_q.size();
        fail_count    <= mismatches;
    end

endmodule

### verif/tb_box_filter_3x3_rgb_unit.sv
`timescale 1ns / 1ps

module tb_box_filter_3x3_rgb_unit;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int ITEM_TARGET  = 1700;
    localparam int IDLE_LIMIT   = 4000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CFW          = bf3_pkg::CFG_W;
    localparam int CHW          = bf3_pkg::CH_W;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [23:0]      s_tdata;
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [23:0]      m_tdata;
    logic             m_tlast;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [0:0]       cfg_index;
    logic [CFW-1:0]   cfg_data;

    int               pending_items;
    int               fail_count;
    logic             long_hold_req;

    // Stimulus view of the frame: sizes in effect and position of the next item.
    int unsigned      eff_w;
    int unsigned      eff_h;
    int unsigned      pos_row;
    int unsigned      pos_col;
    int               items_sent;
    int               send_calm;
    int               recv_calm;

    box_filter_3x3_rgb_unit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bf3_mean_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) mean_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending_items (pending_items),
        .fail_count    (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned eff_size(input logic [CFW-1:0] v, input int unsigned limit);
        if (v == '0) begin
            return 1;
        end
        if (32'(v) > limit) begin
            return limit;
        end
        return 32'(v);
    endfunction

    // Gap before the next handshake: mostly none or short, a few long, and
    // now and then a calm stretch with no gaps at all.
    function automatic int next_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 2) begin
            calm = int'($urandom_range(30, 150));
            return 0;
        end
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return int'($urandom_range(1, 3));
        end
        if (r < 97) begin
            return int'($urandom_range(4, 12));
        end
        return int'($urandom_range(20, 60));
    endfunction

    function automatic bf3_pkg::pixel_t pixel_value();
        bf3_pkg::pixel_t v;
        int              ch;
        v = '0;
        case ($urandom_range(0, 7))
            0: begin
                v = '0;
            end
            1: begin
                v = '1;
            end
            2: begin
                for (ch = 0; ch < bf3_pkg::NUM_CH; ch++) begin
                    v[ch*CHW +: CHW] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                end
            end
            default: begin
                v = bf3_pkg::pixel_t'($urandom);
            end
        endcase
        return v;
    endfunction

    // A position left outside the frame by a size change restarts at the origin.
    function automatic void align_position();
        if (pos_col >= eff_w || pos_row > eff_h + 1) begin
            pos_col = 0;
            pos_row = 0;
        end
    endfunction

    function automatic int unsigned items_to_frame_end();
        align_position();
        if (pos_row == eff_h + 1 && pos_col != 0) begin
            return eff_w - pos_col;
        end
        return (eff_h + 1) * eff_w - (pos_row * eff_w + pos_col) + 1;
    endfunction

    // Offers one item after a random gap and follows the frame position.
    task automatic feed_fixed(input bf3_pkg::item_kind_t kind, input bf3_pkg::pixel_t data);
        int gap;
        align_position();
        gap = next_gap(send_calm);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (pos_row == eff_h + 1 && pos_col == 0) begin
            pos_row = 0;
            pos_col = 0;
        end else begin
            pos_col++;
            if (pos_col >= eff_w) begin
                pos_col = 0;
                pos_row++;
            end
        end
    endtask

    // Mostly pixels inside the image and flushes below it, with some of each
    // swapped in as noise.
    task automatic feed_item();
        bf3_pkg::item_kind_t kind;
        align_position();
        if (pos_row < eff_h) begin
            kind = ($urandom_range(0, 15) == 0) ? bf3_pkg::KIND_FLUSH : bf3_pkg::KIND_PIXEL;
        end else begin
            kind = ($urandom_range(0, 3) == 0) ? bf3_pkg::KIND_PIXEL : bf3_pkg::KIND_FLUSH;
        end
        feed_fixed(kind, pixel_value());
    endtask

    task automatic feed_frame_rest();
        int unsigned n;
        n = items_to_frame_end();
        repeat (n) feed_item();
    endtask

    // Waits until every predicted result has left and the pipeline is empty.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_items != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes both size registers in random order, valid held across the pair.
    task automatic write_sizes(input logic [CFW-1:0] wv, input logic [CFW-1:0] hv);
        logic              width_first;
        bf3_pkg::cfg_reg_t idx;
        int                k;
        width_first = ($urandom_range(0, 1) != 0);
        for (k = 0; k < 2; k++) begin
            idx = ((k == 0) == width_first) ? bf3_pkg::CFG_IMAGE_WIDTH
                                            : bf3_pkg::CFG_IMAGE_HEIGHT;
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= (idx == bf3_pkg::CFG_IMAGE_WIDTH) ? wv : hv;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        eff_w = eff_size(wv, MAX_WIDTH);
        eff_h = eff_size(hv, MAX_HEIGHT);
    endtask

    // Result side: random gaps and one long hold-off on request.
    initial begin
        int gap_left;
        int hold_left;
        bit hold_done;
        m_tready <= 1'b0;
        gap_left  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        recv_calm = 0;
        forever begin
            @(posedge aclk);
            if (long_hold_req && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                gap_left = next_gap(recv_calm);
            end
        end
    end

    // Ends the run when no channel has moved an item for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int               r;
        int               i;
        int unsigned      k;
        logic [CFW-1:0]   wv;
        logic [CFW-1:0]   hv;

        aresetn       <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= bf3_pkg::KIND_PIXEL;
        cfg_valid     <= 1'b0;
        cfg_index     <= bf3_pkg::CFG_IMAGE_WIDTH;
        cfg_data      <= '0;
        long_hold_req <= 1'b0;
        eff_w      = eff_size(bf3_pkg::CFG_RESET, MAX_WIDTH);
        eff_h      = eff_size(bf3_pkg::CFG_RESET, MAX_HEIGHT);
        pos_row    = 0;
        pos_col    = 0;
        items_sent = 0;
        send_calm  = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Start a frame at the reset sizes, then widen past the maximum and
        // set a zero height while inside the first row.
        feed_fixed(bf3_pkg::KIND_PIXEL, '0);
        feed_fixed(bf3_pkg::KIND_PIXEL, '1);
        feed_fixed(bf3_pkg::KIND_FLUSH, 24'h5A_C3_96);
        wait_idle();
        write_sizes(9'd300, 9'd0);

        // The widest frame fills both line buffers; part way into its flush
        // rows the receiver holds off long enough for the input to stall.
        repeat (300) feed_item();
        long_hold_req <= 1'b1;
        feed_frame_rest();

        // Single pixel frame, saturated, with a pixel item in the flush span.
        wait_idle();
        write_sizes(9'd1, 9'd1);
        feed_fixed(bf3_pkg::KIND_PIXEL, '1);
        feed_fixed(bf3_pkg::KIND_FLUSH, '1);
        feed_fixed(bf3_pkg::KIND_PIXEL, '1);

        // Saturated 3x3 frame whose center is a flush item.
        wait_idle();
        write_sizes(9'd3, 9'd3);
        for (i = 0; i < 13; i++) begin
            if (i == 4 || (i >= 9 && i != 11)) begin
                feed_fixed(bf3_pkg::KIND_FLUSH, '1);
            end else begin
                feed_fixed(bf3_pkg::KIND_PIXEL, '1);
            end
        end

        // Width drops to zero mid-frame, which restarts the frame.
        wait_idle();
        write_sizes(9'd4, 9'd3);
        repeat (6) feed_item();
        wait_idle();
        write_sizes(9'd0, 9'd2);
        feed_frame_rest();

        // Random frames, mostly small, some at the size extremes, and some
        // cut short so that the next size change lands inside a frame.
        while (items_sent < ITEM_TARGET) begin
            r = int'($urandom_range(0, 19));
            if (r == 0) begin
                case ($urandom_range(0, 2))
                    0: wv = CFW'(MAX_WIDTH);
                    1: wv = 9'd300;
                    default: wv = '1;
                endcase
                hv = CFW'($urandom_range(0, 1));
            end else if (r == 1) begin
                wv = CFW'($urandom_range(0, 1));
                case ($urandom_range(0, 2))
                    0: hv = CFW'(MAX_HEIGHT);
                    1: hv = 9'd300;
                    default: hv = '1;
                endcase
            end else begin
                wv = CFW'($urandom_range(1, 9));
                hv = CFW'($urandom_range(1, 7));
                if ($urandom_range(0, 15) == 0) begin
                    wv = '0;
                end
                if ($urandom_range(0, 15) == 0) begin
                    hv = '0;
                end
            end
            wait_idle();
            write_sizes(wv, hv);
            if ($urandom_range(0, 3) == 0) begin
                k = $urandom_range(1, items_to_frame_end());
                repeat (k) feed_item();
            end else begin
                feed_frame_rest();
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
